// File: hw/rtl/trms_pkg.sv
// Shared types and constants of the running-minimum scan block.
package trms_pkg;

	localparam int ORDER_BITS_DEF = 10;
	localparam int ACC_BITS_DEF   = 64;
	localparam int EULER_BITS     = 3;
	localparam int CFG_IDX_BITS   = 3;
	localparam int FIBERS         = 3;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_ORDER_0 = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ORDER_1 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ORDER_2 = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TWIST_0 = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TWIST_1 = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_TWIST_2 = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_EULER   = 3'd6;

	// Reset values of the configuration registers
	localparam int ORDER_0_RST = 2;
	localparam int ORDER_1_RST = 3;
	localparam int ORDER_2_RST = 5;
	localparam int TWIST_0_RST = 1;
	localparam int TWIST_1_RST = 2;
	localparam int TWIST_2_RST = 4;
	localparam logic [EULER_BITS-1:0] EULER_RST = 3'b110;

	// Commands from controller to datapath
	typedef struct packed {
		logic start;     // capture tag, form a0*a1, clear scan state
		logic mul2;      // form scan length from a0*a1*a2
		logic scan;      // take minimum, advance one step unless at the end
		logic load_out;  // move final minimum into the output register
	} trms_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic last_hit;  // step index equals scan length
		logic out_free;  // output register can take a result this cycle
	} trms_stat_t;

endpackage

// File: hw/rtl/tau_running_minimum_scan_core.sv
// Top level of the running-minimum scan block: configuration registers and wiring.
//
// Usage:
//   Write the fiber orders, twists and Euler integer part through the plain
//   write port (cfg_we, cfg_index, cfg_data) while the block is idle; a write
//   is taken at the clock edge where cfg_we is high and applies to the next
//   request. Indexes beyond the register list are dropped.
//   Send a request tag on the input channel (in_valid/in_ready). The block
//   answers each transaction with one result transaction on the output
//   channel (out_valid/out_ready): the minimum of the running sum over the
//   scan, saturated to 32 bits, the echoed tag and an overflow flag.
// Sequence:
//   The accepting edge captures the tag and forms a0*a1, the next cycle
//   forms the scan length M = floor(a0*a1*a2/2), then the scan loop runs
//   one step per cycle over j = 0 .. M and loads the result at its last
//   step. At the reset values M = 15. The next request is taken the cycle
//   after the result is loaded, while that result may still wait; the
//   block takes no new request while a scan is under way.
// Reset and stall:
//   arst_n clears the controller, the output valid and the configuration
//   registers to their reset values. A stalled receiver holds the result in
//   the output register; a following scan then holds at its last step until
//   the output register frees up.
module tau_running_minimum_scan_core #(
	parameter int ORDER_BITS = trms_pkg::ORDER_BITS_DEF,
	parameter int ACC_BITS   = trms_pkg::ACC_BITS_DEF,
	parameter int CFG_W      = (ORDER_BITS > trms_pkg::EULER_BITS) ?
	                           ORDER_BITS : trms_pkg::EULER_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        request_tag,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                minimum_value,
	output logic [7:0]                        result_tag,
	output logic                              overflow_flag,
	input  logic                              cfg_we,
	input  logic [trms_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data
);
	import trms_pkg::*;

	logic [2:0][ORDER_BITS-1:0] order_q;
	logic [2:0][ORDER_BITS-1:0] twist_q;
	logic [EULER_BITS-1:0]      euler_q;
	trms_cmd_t                  cmd;
	trms_stat_t                 stat;

	// Configuration registers; keep only the low bits of each write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q[0] <= ORDER_BITS'(ORDER_0_RST);
			order_q[1] <= ORDER_BITS'(ORDER_1_RST);
			order_q[2] <= ORDER_BITS'(ORDER_2_RST);
			twist_q[0] <= ORDER_BITS'(TWIST_0_RST);
			twist_q[1] <= ORDER_BITS'(TWIST_1_RST);
			twist_q[2] <= ORDER_BITS'(TWIST_2_RST);
			euler_q    <= EULER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORDER_0: order_q[0] <= cfg_data[ORDER_BITS-1:0];
				REG_ORDER_1: order_q[1] <= cfg_data[ORDER_BITS-1:0];
				REG_ORDER_2: order_q[2] <= cfg_data[ORDER_BITS-1:0];
				REG_TWIST_0: twist_q[0] <= cfg_data[ORDER_BITS-1:0];
				REG_TWIST_1: twist_q[1] <= cfg_data[ORDER_BITS-1:0];
				REG_TWIST_2: twist_q[2] <= cfg_data[ORDER_BITS-1:0];
				REG_EULER:   euler_q    <= cfg_data[EULER_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequence start, length setup, scan and result load
	trms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Fiber counters, running sum and minimum, output register
	trms_dp #(
		.ORDER_BITS (ORDER_BITS),
		.ACC_BITS   (ACC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.order         (order_q),
		.twist         (twist_q),
		.euler         (euler_q),
		.request_tag   (request_tag),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.minimum_value (minimum_value),
		.result_tag    (result_tag),
		.overflow_flag (overflow_flag)
	);

endmodule

// File: hw/rtl/trms_ctrl.sv
// Controller state machine of the running-minimum scan block.
module trms_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  trms_pkg::trms_stat_t stat,
	output trms_pkg::trms_cmd_t  cmd
);
	import trms_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.last_hit && stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/trms_dp.sv
// Datapath of the running-minimum scan block: scan length, fiber counters, sums.
module trms_dp #(
	parameter int ORDER_BITS = trms_pkg::ORDER_BITS_DEF,
	parameter int ACC_BITS   = trms_pkg::ACC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  trms_pkg::trms_cmd_t                  cmd,
	output trms_pkg::trms_stat_t                 stat,
	input  logic [2:0][ORDER_BITS-1:0]           order,
	input  logic [2:0][ORDER_BITS-1:0]           twist,
	input  logic [trms_pkg::EULER_BITS-1:0]      euler,
	input  logic [7:0]                           request_tag,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [31:0]                   minimum_value,
	output logic [7:0]                           result_tag,
	output logic                                 overflow_flag
);
	import trms_pkg::*;

	localparam int P1_W = 2 * ORDER_BITS;
	localparam int P2_W = 3 * ORDER_BITS;
	localparam int J_W  = P2_W - 1;
	localparam logic [ACC_BITS-1:0] SAT_LIMIT = ~(ACC_BITS'(32'h7fff_ffff));

	logic [P1_W-1:0]     p1_q;
	logic [P2_W-1:0]     p2;
	logic [J_W-1:0]      last_q;
	logic [J_W-1:0]      step_q;
	logic [7:0]          tag_q;
	logic [ORDER_BITS-1:0] rem_q [FIBERS];
	logic [ACC_BITS-1:0]   quo_q [FIBERS];
	logic [ORDER_BITS-1:0] rem_d [FIBERS];
	logic                  wrap  [FIBERS];
	logic [ACC_BITS-1:0] ite_q;
	logic [ACC_BITS-1:0] sum_q;
	logic [ACC_BITS-1:0] min_q;
	logic [ACC_BITS-1:0] min_d;
	logic [ACC_BITS-1:0] delta;
	logic [ACC_BITS-1:0] euler_ext;
	logic                ovf;
	logic                out_valid_q;

	assign p2        = P2_W'(p1_q) * P2_W'(order[2]);
	assign euler_ext = {{(ACC_BITS-EULER_BITS){euler[EULER_BITS-1]}}, euler};
	assign min_d     = ($signed(sum_q) < $signed(min_q)) ? sum_q : min_q;

	always_comb begin
		logic [ORDER_BITS:0] s;
		delta = ACC_BITS'(1) - ite_q;
		for (int i = 0; i < FIBERS; i++) begin
			delta = delta - quo_q[i] - ACC_BITS'(rem_q[i] != '0);
			s       = {1'b0, rem_q[i]} + {1'b0, twist[i]};
			wrap[i] = (s >= {1'b0, order[i]});
			if (wrap[i]) begin
				s = s - {1'b0, order[i]};
			end
			rem_d[i] = s[ORDER_BITS-1:0];
		end
	end

	assign ovf           = $signed(min_d) < $signed(SAT_LIMIT);
	assign stat.last_hit = (step_q == last_q);
	assign stat.out_free = !out_valid_q || out_ready;

	// Scan state: cleared on start, advanced once per scan cycle until the last step
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			tag_q  <= request_tag;
			p1_q   <= P1_W'(order[0]) * P1_W'(order[1]);
			step_q <= '0;
			ite_q  <= '0;
			sum_q  <= '0;
			min_q  <= '0;
			for (int i = 0; i < FIBERS; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end
		if (cmd.mul2) begin
			last_q <= p2[P2_W-1:1];
		end
		if (cmd.scan) begin
			min_q <= min_d;
			if (!stat.last_hit) begin
				step_q <= step_q + J_W'(1);
				sum_q  <= sum_q + delta;
				ite_q  <= ite_q + euler_ext;
				for (int i = 0; i < FIBERS; i++) begin
					rem_q[i] <= rem_d[i];
					quo_q[i] <= quo_q[i] + ACC_BITS'(wrap[i]);
				end
			end
		end
	end

	// Output register: holds a result until the receiver takes it
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			minimum_value <= ovf ? 32'sh8000_0000 : $signed(min_d[31:0]);
			overflow_flag <= ovf;
			result_tag    <= tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the running-minimum scan core.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import trms_pkg::*;

	// Register index that lies beyond the register list; writes to it are dropped.
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam int     RANDOM_ITEMS   = 950;
	localparam int     DRAIN_CYCLES   = 8;
	localparam longint CYCLE_LIMIT    = 20_000_000;
	localparam longint RESULT_FLOOR   = -64'sd2147483648;
	localparam int     PRINTED_ERRORS = 40;

	typedef struct {
		logic signed [31:0] minimum;
		logic [7:0]         tag;
		logic               overflow;
	} scan_result_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    in_valid      = 1'b0;
	logic                    in_ready;
	logic [7:0]              request_tag   = 8'd0;
	logic                    out_valid;
	logic                    out_ready     = 1'b0;
	logic signed [31:0]      minimum_value;
	logic [7:0]              result_tag;
	logic                    overflow_flag;
	logic                    cfg_we        = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index     = '0;
	logic [9:0]              cfg_data      = '0;

	// Shadow copy of the configuration registers, as the block holds them.
	logic [9:0] order_reg [3] = '{10'(ORDER_0_RST), 10'(ORDER_1_RST), 10'(ORDER_2_RST)};
	logic [9:0] twist_reg [3] = '{10'(TWIST_0_RST), 10'(TWIST_1_RST), 10'(TWIST_2_RST)};
	logic [2:0] euler_reg     = EULER_RST;

	logic [7:0]   request_backlog [$];   // tags waiting to be offered
	scan_result_t expected_minima [$];   // predicted results, oldest first
	logic         in_taken      = 1'b0;  // request accepted at the last rising edge
	int           send_gap      = 0;
	int           stall_left    = 0;
	bit           no_idle       = 1'b0;
	int           mismatch_count = 0;
	longint       cycle_count   = 0;

	tau_running_minimum_scan_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.request_tag  (request_tag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.minimum_value(minimum_value),
		.result_tag   (result_tag),
		.overflow_flag(overflow_flag),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run one scan over j = 0 .. floor(a0*a1*a2/2) and keep the lowest running sum.
	// Each ceiling is quotient plus one when the remainder is nonzero; the remainder
	// advances by the twist with a single conditional subtraction of the order.
	function automatic scan_result_t predict_minimum(input logic [7:0] tag);
		scan_result_t      res;
		longint unsigned   span;
		longint unsigned   step;
		longint            tau;
		longint            lowest;
		longint            euler_acc;
		longint            euler_val;
		longint            delta;
		longint            quo [3];
		int                rem [3];
		int                s;
		int                i;
		span = (longint'(order_reg[0]) * longint'(order_reg[1]) *
		        longint'(order_reg[2])) >> 1;
		euler_val = longint'($signed(euler_reg));
		tau = 0;
		lowest = 0;
		euler_acc = 0;
		for (i = 0; i < 3; i++) begin
			quo[i] = 0;
			rem[i] = 0;
		end
		for (step = 0; step <= span; step++) begin
			if (tau < lowest)
				lowest = tau;
			if (step != span) begin
				delta = 1 - euler_acc;
				for (i = 0; i < 3; i++)
					delta -= quo[i] + ((rem[i] != 0) ? 1 : 0);
				tau += delta;
				euler_acc += euler_val;
				for (i = 0; i < 3; i++) begin
					s = rem[i] + int'(twist_reg[i]);
					if (s >= int'(order_reg[i])) begin
						s -= int'(order_reg[i]);
						quo[i]++;
					end
					rem[i] = s & 'h3FF;
				end
			end
		end
		res.overflow = (lowest < RESULT_FLOOR);
		res.minimum  = res.overflow ? 32'sh8000_0000 : 32'(lowest);
		res.tag      = tag;
		return res;
	endfunction

	// Mostly short idle stretches, now and then a long one; none in burst phases.
	function automatic int draw_idle();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(0, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < PRINTED_ERRORS)
			$display("tb: cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Driver: offer the next tag once the previous transaction is gone and the gap
	// has run out. Hold valid and payload steady until accepted.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (request_backlog.size() != 0) begin
				in_valid    <= 1'b1;
				request_tag <= request_backlog.pop_front();
				send_gap    <= draw_idle();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random, in short and long stretches.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 99) < 20) begin
			out_ready  <= 1'b0;
			stall_left <= draw_idle();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: predict at each accepted request, compare each accepted result with
	// the oldest prediction.
	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				expected_minima.push_back(predict_minimum(request_tag));
			if (out_valid && out_ready) begin
				if (expected_minima.size() == 0) begin
					report_mismatch("result with no request outstanding, tag", result_tag, -1);
				end else begin
					want = expected_minima.pop_front();
					if (minimum_value !== want.minimum)
						report_mismatch("minimum_value", minimum_value, want.minimum);
					if (result_tag !== want.tag)
						report_mismatch("result_tag", result_tag, want.tag);
					if (overflow_flag !== want.overflow)
						report_mismatch("overflow_flag", overflow_flag, want.overflow);
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tau_running_minimum_scan_core: mismatch");
			$finish;
		end
	end

	// Wait until every offered request has been answered, then let the block settle.
	task automatic settle();
		while (request_backlog.size() != 0 || in_valid || expected_minima.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all seven registers, sometimes with a dropped write to an unused index.
	// Only call while the block is idle.
	task automatic program_scan(input logic [9:0] o0, input logic [9:0] o1,
	                            input logic [9:0] o2, input logic [9:0] w0,
	                            input logic [9:0] w1, input logic [9:0] w2,
	                            input logic [2:0] e);
		logic [9:0]              values [7];
		logic [CFG_IDX_BITS-1:0] regs [7];
		int                      i;
		values = '{o0, o1, o2, w0, w1, w2, {7'($urandom), e}};
		regs   = '{REG_ORDER_0, REG_ORDER_1, REG_ORDER_2, REG_TWIST_0,
		           REG_TWIST_1, REG_TWIST_2, REG_EULER};
		for (i = 0; i < 7; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= values[i];
		end
		if ($urandom_range(0, 3) == 0) begin
			@(negedge clk);
			cfg_index <= REG_UNUSED;
			cfg_data  <= 10'($urandom);
		end
		@(negedge clk);
		cfg_we    <= 1'b0;
		order_reg = '{o0, o1, o2};
		twist_reg = '{w0, w1, w2};
		euler_reg = e;
	endtask

	// Directed setting: program, then send each item alone and wait for its answer.
	task automatic run_directed(input logic [9:0] o0, input logic [9:0] o1,
	                            input logic [9:0] o2, input logic [9:0] w0,
	                            input logic [9:0] w1, input logic [9:0] w2,
	                            input logic [2:0] e, input int count);
		int k;
		settle();
		program_scan(o0, o1, o2, w0, w1, w2, e);
		for (k = 0; k < count; k++) begin
			@(posedge clk);
			request_backlog.push_back(8'($urandom));
			settle();
		end
	endtask

	// Pick a random setting. Most use small orders so scans stay short; a few
	// put one fiber at a large, zero or unit order. Twists sometimes reach or
	// pass the order, and the Euler part sometimes leaves its usual range.
	task automatic random_setup(output bit is_long);
		logic [9:0] ord [3];
		logic [9:0] tw [3];
		logic [2:0] e;
		int         pick;
		int         r;
		int         big;
		int         i;
		pick = $urandom_range(0, 99);
		is_long = 1'b0;
		for (i = 0; i < 3; i++) begin
			if (pick < 75)
				ord[i] = 10'($urandom_range(2, 7));
			else if (pick < 85)
				ord[i] = 10'($urandom_range(2, 12));
			else
				ord[i] = 10'($urandom_range(0, 12));
		end
		if (pick >= 90) begin
			is_long = 1'b1;
			big = $urandom_range(0, 2);
			for (i = 0; i < 3; i++)
				ord[i] = 10'($urandom_range(2, 3));
			case ($urandom_range(0, 3))
				0: ord[big] = 10'd1023;
				1: ord[big] = 10'($urandom_range(0, 1023));
				2: ord[big] = 10'($urandom_range(0, 1));
				default: ord[big] = 10'($urandom_range(512, 1023));
			endcase
		end
		for (i = 0; i < 3; i++) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				tw[i] = (ord[i] >= 2) ? 10'($urandom_range(1, ord[i] - 1)) :
				                        10'($urandom_range(0, 2));
			else if (r < 88)
				tw[i] = ord[i];
			else if (r < 94)
				tw[i] = 10'd0;
			else
				tw[i] = 10'($urandom_range(0, 1023));
		end
		if ($urandom_range(0, 4) != 0)
			e = 3'(-int'($urandom_range(1, 3)));
		else
			e = 3'($urandom_range(0, 7));
		program_scan(ord[0], ord[1], ord[2], tw[0], tw[1], tw[2], e);
	endtask

	initial begin
		int random_sent;
		int n;
		int k;
		bit is_long;
		random_sent = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Reset setting, tag extremes; each request waits out the one before.
		repeat (2) @(posedge clk);
		request_backlog.push_back(8'h00);
		settle();
		request_backlog.push_back(8'hFF);
		settle();

		// Orders all at two, the smallest usual order.
		run_directed(10'd2, 10'd2, 10'd2, 10'd1, 10'd1, 10'd1, 3'b111, 1);
		// Largest order with the largest twist below it, most negative usual Euler part.
		run_directed(10'd1023, 10'd2, 10'd2, 10'd1022, 10'd1, 10'd1, 3'b101, 1);
		run_directed(10'd2, 10'd3, 10'd1023, 10'd1, 10'd2, 10'd511, 3'b111, 1);
		// Zero order: scan length zero, result stays at the start value.
		run_directed(10'd0, 10'd5, 10'd7, 10'd3, 10'd4, 10'd6, 3'b110, 1);
		// Two unit orders, one with a twist past the order and one with a zero twist.
		run_directed(10'd1, 10'd1, 10'd3, 10'd5, 10'd0, 10'd2, 3'b110, 1);
		// Twists not below the order, positive Euler part.
		run_directed(10'd3, 10'd4, 10'd5, 10'd3, 10'd9, 10'd1023, 3'b011, 2);
		// Euler part at the bottom of its field, then zero.
		run_directed(10'd4, 10'd5, 10'd6, 10'd1, 10'd2, 10'd3, 3'b100, 1);
		run_directed(10'd6, 10'd5, 10'd4, 10'd5, 10'd4, 10'd3, 3'b000, 1);
		// Deep minimum that still fits in 32 bits.
		run_directed(10'd40, 10'd40, 10'd30, 10'd1023, 10'd1023, 10'd1023, 3'b011, 1);
		// Minimum below the 32-bit range: saturate and flag.
		run_directed(10'd40, 10'd40, 10'd40, 10'd1023, 10'd1023, 10'd1023, 3'b011, 2);

		// Random phases: new setting, then a batch of requests with random tags.
		while (random_sent < RANDOM_ITEMS) begin
			settle();
			random_setup(is_long);
			no_idle = ($urandom_range(0, 4) == 0);
			@(posedge clk);
			n = is_long ? $urandom_range(4, 10) : $urandom_range(20, 60);
			for (k = 0; k < n; k++)
				request_backlog.push_back(8'($urandom));
			random_sent += n;
		end

		settle();
		if (mismatch_count == 0)
			$display("tau_running_minimum_scan_core: match");
		else
			$display("tau_running_minimum_scan_core: mismatch");
		$finish;
	end

endmodule
